// File: src/cvmc_pkg.sv
`default_nettype none
package cvmc_pkg;

  // Command codes
  localparam logic [3:0] CMD_SET_MODE    = 4'd0;
  localparam logic [3:0] CMD_OFF         = 4'd1;
  localparam logic [3:0] CMD_COMP_TANK   = 4'd2;
  localparam logic [3:0] CMD_COMP_NUT    = 4'd3;
  localparam logic [3:0] CMD_COMP_WATER  = 4'd4;
  localparam logic [3:0] CMD_NUT_OPEN    = 4'd5;
  localparam logic [3:0] CMD_NUT_CLOSE   = 4'd6;
  localparam logic [3:0] CMD_WATER_OPEN  = 4'd7;
  localparam logic [3:0] CMD_WATER_CLOSE = 4'd8;
  localparam logic [3:0] CMD_KEEP_LINK   = 4'd9;

  // Mode numbers
  localparam logic [7:0] MODE_IDLE       = 8'd0;
  localparam logic [7:0] MODE_OFF        = 8'd1;
  localparam logic [7:0] MODE_TANK       = 8'd2;
  localparam logic [7:0] MODE_NUT        = 8'd3;
  localparam logic [7:0] MODE_WATER      = 8'd4;
  localparam logic [7:0] MODE_TANK_WATER = 8'd5;
  localparam logic [7:0] MODE_ALL        = 8'd6;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUT_INV   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TANK_INV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_INV = 2'd2;

  typedef struct packed {
    logic nut;
    logic tank;
    logic water;
  } inv_t;

  typedef struct packed {
    logic       compressor;
    logic       tank_raw;
    logic       nut_raw;
    logic       water_raw;
    logic       nut_vent;
    logic       water_vent;
    logic       keep;
    logic [7:0] mode;
  } ctrl_state_t;

endpackage
`default_nettype wire

// File: src/cvmc_step.sv
`default_nettype none
module cvmc_step (
  input  wire cvmc_pkg::ctrl_state_t state_i,
  input  wire cvmc_pkg::inv_t        inv_i,
  input  wire logic [3:0]            cmd_i,
  input  wire logic [7:0]            mode_value_i,
  input  wire logic                  connect_i,
  output cvmc_pkg::ctrl_state_t      state_o,
  output logic [1:0]                 status_o
);

  // Store mode and set compressor and raw valve bits for it
  function automatic cvmc_pkg::ctrl_state_t apply_mode(
    input cvmc_pkg::ctrl_state_t s,
    input cvmc_pkg::inv_t        inv,
    input logic [7:0]            m
  );
    cvmc_pkg::ctrl_state_t r;
    r = s;
    r.mode = m;
    case (m)
      cvmc_pkg::MODE_OFF: begin
        r.compressor = 1'b0; r.tank_raw = 1'b0; r.nut_raw = s.keep; r.water_raw = 1'b0;
      end
      cvmc_pkg::MODE_TANK: begin
        r.compressor = 1'b1; r.tank_raw = 1'b1; r.nut_raw = s.keep; r.water_raw = 1'b0;
      end
      cvmc_pkg::MODE_NUT: begin
        r.compressor = 1'b1; r.tank_raw = 1'b1; r.nut_raw = 1'b1; r.water_raw = 1'b0;
      end
      cvmc_pkg::MODE_WATER: begin
        r.compressor = 1'b1; r.tank_raw = 1'b0; r.nut_raw = s.keep; r.water_raw = 1'b1;
      end
      cvmc_pkg::MODE_TANK_WATER: begin
        r.compressor = 1'b1; r.tank_raw = 1'b1; r.nut_raw = s.keep; r.water_raw = 1'b1;
      end
      cvmc_pkg::MODE_ALL: begin
        r.compressor = 1'b1; r.tank_raw = 1'b1; r.nut_raw = 1'b1; r.water_raw = 1'b1;
      end
      default: begin
        // idle and unknown modes: every drive reads low
        r.compressor = 1'b0; r.tank_raw = inv.tank; r.nut_raw = inv.nut;
        r.water_raw = inv.water;
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mode_status(input logic [7:0] m);
    return (m > cvmc_pkg::MODE_ALL) ? cvmc_pkg::ST_UNKNOWN : cvmc_pkg::ST_DONE;
  endfunction

  logic [7:0] m;
  assign m = state_i.mode;

  // Decode the command against current state
  always_comb begin
    state_o  = state_i;
    status_o = cvmc_pkg::ST_SAME;
    case (cmd_i)
      cvmc_pkg::CMD_SET_MODE: begin
        state_o  = apply_mode(state_i, inv_i, mode_value_i);
        status_o = mode_status(mode_value_i);
      end
      cvmc_pkg::CMD_OFF: begin
        state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_OFF);
        status_o = cvmc_pkg::ST_DONE;
      end
      cvmc_pkg::CMD_COMP_TANK: begin
        if (state_i.nut_raw) begin
          status_o = cvmc_pkg::ST_REFUSED;
        end else if (m == cvmc_pkg::MODE_WATER) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_TANK_WATER);
          status_o = cvmc_pkg::ST_DONE;
        end else if (!(m inside {cvmc_pkg::MODE_TANK, cvmc_pkg::MODE_NUT,
                                 cvmc_pkg::MODE_TANK_WATER, cvmc_pkg::MODE_ALL})) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_TANK);
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_COMP_NUT: begin
        if (state_i.nut_vent) begin
          status_o = cvmc_pkg::ST_REFUSED;
        end else if (m inside {cvmc_pkg::MODE_WATER, cvmc_pkg::MODE_TANK_WATER}) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_ALL);
          status_o = cvmc_pkg::ST_DONE;
        end else if (!(m inside {cvmc_pkg::MODE_NUT, cvmc_pkg::MODE_ALL})) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_NUT);
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_COMP_WATER: begin
        if (state_i.water_vent) begin
          status_o = cvmc_pkg::ST_REFUSED;
        end else if (m == cvmc_pkg::MODE_TANK) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_TANK_WATER);
          status_o = cvmc_pkg::ST_DONE;
        end else if (m == cvmc_pkg::MODE_NUT) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_ALL);
          status_o = cvmc_pkg::ST_DONE;
        end else if (!(m inside {cvmc_pkg::MODE_WATER, cvmc_pkg::MODE_TANK_WATER,
                                 cvmc_pkg::MODE_ALL})) begin
          state_o  = apply_mode(state_i, inv_i, cvmc_pkg::MODE_WATER);
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_NUT_OPEN: begin
        if (state_i.nut_raw) begin
          status_o = cvmc_pkg::ST_REFUSED;
        end else if (!state_i.nut_vent) begin
          state_o.nut_vent = 1'b1;
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_NUT_CLOSE: begin
        if (state_i.nut_vent) begin
          state_o.nut_vent = 1'b0;
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_WATER_OPEN: begin
        if (state_i.water_raw) begin
          status_o = cvmc_pkg::ST_REFUSED;
        end else if (!state_i.water_vent) begin
          state_o.water_vent = 1'b1;
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_WATER_CLOSE: begin
        if (state_i.water_vent) begin
          state_o.water_vent = 1'b0;
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_KEEP_LINK: begin
        if (state_i.keep != connect_i) begin
          state_o.keep = connect_i;
          if (connect_i) begin
            state_o.nut_raw = 1'b1;
          end else if (!(m inside {cvmc_pkg::MODE_NUT, cvmc_pkg::MODE_ALL})) begin
            state_o.nut_raw = 1'b0;
          end
          status_o = cvmc_pkg::ST_DONE;
        end
      end
      default: begin
        status_o = cvmc_pkg::ST_SAME;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/compressor_valve_mode_controller.sv
`default_nettype none
// Channel  Handshake              Payload
// in_      in_valid / in_ready    in_cmd[3:0], in_mode_value[7:0], in_connect
// out_     out_valid / out_ready  drives, vents, current_mode, keep_link, status
// cfg_     cfg_valid / cfg_ready  cfg_index[1:0], cfg_data (inversion bits)
//
// One request per cycle while in_ready is high: the command is decoded
// against the state registers and the state and result register load at
// the same edge. in_ready is high while the result register is empty or
// being drained; cfg_ready is always high. Reset clears all state,
// inversion bits and the result valid flag.
module compressor_valve_mode_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3:0]                    in_cmd,
  input  wire logic [7:0]                    in_mode_value,
  input  wire logic                          in_connect,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_compressor_on,
  output logic                               out_tank_valve_drive,
  output logic                               out_nut_valve_drive,
  output logic                               out_water_valve_drive,
  output logic                               out_nut_vent_open,
  output logic                               out_water_vent_open,
  output logic [7:0]                         out_current_mode,
  output logic                               out_keep_link,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cvmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data
);

  cvmc_pkg::ctrl_state_t state_r, state_nxt;
  cvmc_pkg::inv_t        inv_r;
  logic [1:0]            status_nxt;
  logic                  in_fire;
  logic                  out_valid_r;

  logic       comp_r, tank_drv_r, nut_drv_r, water_drv_r, nut_vent_r, water_vent_r;
  logic [7:0] mode_r;
  logic       keep_r;
  logic [1:0] status_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  cvmc_step u_step (
    .state_i      (state_r),
    .inv_i        (inv_r),
    .cmd_i        (in_cmd),
    .mode_value_i (in_mode_value),
    .connect_i    (in_connect),
    .state_o      (state_nxt),
    .status_o     (status_nxt)
  );

  // Write inversion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cvmc_pkg::CFG_NUT_INV:   inv_r.nut   <= cfg_data;
        cvmc_pkg::CFG_TANK_INV:  inv_r.tank  <= cfg_data;
        cvmc_pkg::CFG_WATER_INV: inv_r.water <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Hold result valid until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      comp_r       <= state_nxt.compressor;
      tank_drv_r   <= state_nxt.tank_raw ^ inv_r.tank;
      nut_drv_r    <= state_nxt.nut_raw ^ inv_r.nut;
      water_drv_r  <= state_nxt.water_raw ^ inv_r.water;
      nut_vent_r   <= state_nxt.nut_vent;
      water_vent_r <= state_nxt.water_vent;
      mode_r       <= state_nxt.mode;
      keep_r       <= state_nxt.keep;
      status_r     <= status_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_compressor_on     = comp_r;
  assign out_tank_valve_drive  = tank_drv_r;
  assign out_nut_valve_drive   = nut_drv_r;
  assign out_water_valve_drive = water_drv_r;
  assign out_nut_vent_open     = nut_vent_r;
  assign out_water_vent_open   = water_vent_r;
  assign out_current_mode      = mode_r;
  assign out_keep_link         = keep_r;
  assign out_status            = status_r;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned NUM_PHASES  = 6;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] mode_value;
    logic       connect;
  } cmd_req_t;

  typedef struct packed {
    logic       compressor_on;
    logic       tank_drive;
    logic       nut_drive;
    logic       water_drive;
    logic       nut_vent;
    logic       water_vent;
    logic [7:0] mode;
    logic       keep;
    logic [1:0] status;
  } report_t;

  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           in_valid      = 1'b0;
  logic                           in_ready;
  logic [3:0]                     in_cmd        = '0;
  logic [7:0]                     in_mode_value = '0;
  logic                           in_connect    = 1'b0;
  logic                           out_valid;
  logic                           out_ready     = 1'b0;
  logic                           out_compressor_on;
  logic                           out_tank_valve_drive;
  logic                           out_nut_valve_drive;
  logic                           out_water_valve_drive;
  logic                           out_nut_vent_open;
  logic                           out_water_vent_open;
  logic [7:0]                     out_current_mode;
  logic                           out_keep_link;
  logic [1:0]                     out_status;
  logic                           cfg_valid     = 1'b0;
  logic                           cfg_ready;
  logic [cvmc_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic                           cfg_data      = 1'b0;

  // Predicted controller state and valve inversion settings
  cvmc_pkg::ctrl_state_t plant;
  cvmc_pkg::inv_t        inv;

  cmd_req_t    cmd_backlog[$];
  report_t     expected_reports[$];

  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned failures      = 0;
  int unsigned reports_seen  = 0;
  int unsigned cmds_taken    = 0;
  int unsigned unused_taken  = 0;
  int unsigned status_hits[4];

  compressor_valve_mode_controller u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_mode_value         (in_mode_value),
    .in_connect            (in_connect),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_compressor_on     (out_compressor_on),
    .out_tank_valve_drive  (out_tank_valve_drive),
    .out_nut_valve_drive   (out_nut_valve_drive),
    .out_water_valve_drive (out_water_valve_drive),
    .out_nut_vent_open     (out_nut_vent_open),
    .out_water_vent_open   (out_water_vent_open),
    .out_current_mode      (out_current_mode),
    .out_keep_link         (out_keep_link),
    .out_status            (out_status),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void load_valves(input logic on, input logic tank, input logic nut,
                                      input logic water);
    plant.compressor = on;
    plant.tank_raw   = tank;
    plant.nut_raw    = nut;
    plant.water_raw  = water;
  endfunction

  // Store a mode and drive the valves for it
  function automatic logic [1:0] enter_mode(input logic [7:0] m);
    logic k;
    k = plant.keep;
    plant.mode = m;
    case (m)
      cvmc_pkg::MODE_IDLE:       load_valves(1'b0, inv.tank, inv.nut, inv.water);
      cvmc_pkg::MODE_OFF:        load_valves(1'b0, 1'b0, k, 1'b0);
      cvmc_pkg::MODE_TANK:       load_valves(1'b1, 1'b1, k, 1'b0);
      cvmc_pkg::MODE_NUT:        load_valves(1'b1, 1'b1, 1'b1, 1'b0);
      cvmc_pkg::MODE_WATER:      load_valves(1'b1, 1'b0, k, 1'b1);
      cvmc_pkg::MODE_TANK_WATER: load_valves(1'b1, 1'b1, k, 1'b1);
      cvmc_pkg::MODE_ALL:        load_valves(1'b1, 1'b1, 1'b1, 1'b1);
      default: begin
        load_valves(1'b0, inv.tank, inv.nut, inv.water);
        return cvmc_pkg::ST_UNKNOWN;
      end
    endcase
    return cvmc_pkg::ST_DONE;
  endfunction

  // Apply one command to the predicted state and return the expected report
  function automatic report_t advance_controller(input cmd_req_t r);
    logic [7:0] m;
    logic [1:0] st;
    report_t    rep;
    m  = plant.mode;
    st = cvmc_pkg::ST_SAME;
    case (r.cmd)
      cvmc_pkg::CMD_SET_MODE: st = enter_mode(r.mode_value);
      cvmc_pkg::CMD_OFF:      st = enter_mode(cvmc_pkg::MODE_OFF);
      cvmc_pkg::CMD_COMP_TANK: begin
        if (plant.nut_raw) st = cvmc_pkg::ST_REFUSED;
        else if (m == cvmc_pkg::MODE_WATER) st = enter_mode(cvmc_pkg::MODE_TANK_WATER);
        else if (!(m inside {cvmc_pkg::MODE_TANK, cvmc_pkg::MODE_NUT,
                             cvmc_pkg::MODE_TANK_WATER, cvmc_pkg::MODE_ALL}))
          st = enter_mode(cvmc_pkg::MODE_TANK);
      end
      cvmc_pkg::CMD_COMP_NUT: begin
        if (plant.nut_vent) st = cvmc_pkg::ST_REFUSED;
        else if (m inside {cvmc_pkg::MODE_WATER, cvmc_pkg::MODE_TANK_WATER})
          st = enter_mode(cvmc_pkg::MODE_ALL);
        else if (!(m inside {cvmc_pkg::MODE_NUT, cvmc_pkg::MODE_ALL}))
          st = enter_mode(cvmc_pkg::MODE_NUT);
      end
      cvmc_pkg::CMD_COMP_WATER: begin
        if (plant.water_vent) st = cvmc_pkg::ST_REFUSED;
        else if (m == cvmc_pkg::MODE_TANK) st = enter_mode(cvmc_pkg::MODE_TANK_WATER);
        else if (m == cvmc_pkg::MODE_NUT) st = enter_mode(cvmc_pkg::MODE_ALL);
        else if (!(m inside {cvmc_pkg::MODE_WATER, cvmc_pkg::MODE_TANK_WATER,
                             cvmc_pkg::MODE_ALL}))
          st = enter_mode(cvmc_pkg::MODE_WATER);
      end
      cvmc_pkg::CMD_NUT_OPEN: begin
        if (plant.nut_raw) st = cvmc_pkg::ST_REFUSED;
        else if (!plant.nut_vent) begin
          plant.nut_vent = 1'b1;
          st = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_NUT_CLOSE: begin
        if (plant.nut_vent) begin
          plant.nut_vent = 1'b0;
          st = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_WATER_OPEN: begin
        if (plant.water_raw) st = cvmc_pkg::ST_REFUSED;
        else if (!plant.water_vent) begin
          plant.water_vent = 1'b1;
          st = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_WATER_CLOSE: begin
        if (plant.water_vent) begin
          plant.water_vent = 1'b0;
          st = cvmc_pkg::ST_DONE;
        end
      end
      cvmc_pkg::CMD_KEEP_LINK: begin
        if (plant.keep != r.connect) begin
          plant.keep = r.connect;
          if (r.connect) plant.nut_raw = 1'b1;
          else if (!(m inside {cvmc_pkg::MODE_NUT, cvmc_pkg::MODE_ALL})) plant.nut_raw = 1'b0;
          st = cvmc_pkg::ST_DONE;
        end
      end
      default: st = cvmc_pkg::ST_SAME;
    endcase
    rep.compressor_on = plant.compressor;
    rep.tank_drive    = plant.tank_raw ^ inv.tank;
    rep.nut_drive     = plant.nut_raw ^ inv.nut;
    rep.water_drive   = plant.water_raw ^ inv.water;
    rep.nut_vent      = plant.nut_vent;
    rep.water_vent    = plant.water_vent;
    rep.mode          = plant.mode;
    rep.keep          = plant.keep;
    rep.status        = st;
    return rep;
  endfunction

  function automatic string show_report(input report_t r);
    return $sformatf("comp=%b tank=%b nut=%b water=%b nvent=%b wvent=%b mode=%0d keep=%b st=%0d",
                     r.compressor_on, r.tank_drive, r.nut_drive, r.water_drive,
                     r.nut_vent, r.water_vent, r.mode, r.keep, r.status);
  endfunction

  function automatic void queue_request(input logic [3:0] cmd, input logic [7:0] mv,
                                        input logic con);
    cmd_backlog.push_back({cmd, mv, con});
  endfunction

  // Mostly legal commands with useful mode numbers, some unused codes as noise
  function automatic cmd_req_t random_request();
    cmd_req_t r;
    if ($urandom_range(99) < 8) r.cmd = 4'($urandom_range(15, cvmc_pkg::CMD_KEEP_LINK + 1));
    else r.cmd = 4'($urandom_range(cvmc_pkg::CMD_KEEP_LINK));
    if (r.cmd == cvmc_pkg::CMD_SET_MODE && $urandom_range(9) < 8)
      r.mode_value = 8'($urandom_range(cvmc_pkg::MODE_ALL));
    else r.mode_value = 8'($urandom_range(255));
    r.connect = 1'($urandom_range(1));
    return r;
  endfunction

  // Driver: present queued requests, predict each one taken
  always @(posedge clk) begin
    cmd_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(advance_controller({in_cmd, in_mode_value, in_connect}));
        cmds_taken++;
        if (in_cmd > cvmc_pkg::CMD_KEEP_LINK) unused_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          in_cmd        <= nxt.cmd;
          in_mode_value <= nxt.mode_value;
          in_connect    <= nxt.connect;
          in_valid      <= 1'b1;
          gap_left      <= pick_gap(in_gap_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each report against the oldest prediction, stall at random
  always @(posedge clk) begin
    report_t got;
    report_t want;
    int unsigned n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_compressor_on, out_tank_valve_drive, out_nut_valve_drive,
               out_water_valve_drive, out_nut_vent_open, out_water_vent_open,
               out_current_mode, out_keep_link, out_status};
        reports_seen++;
        if (expected_reports.size() == 0) begin
          if (failures < 10) $display("[%0t] unexpected report: %s", $time, show_report(got));
          failures++;
        end else begin
          want = expected_reports.pop_front();
          status_hits[want.status]++;
          if (got.compressor_on !== want.compressor_on || got.tank_drive !== want.tank_drive ||
              got.nut_drive !== want.nut_drive || got.water_drive !== want.water_drive ||
              got.nut_vent !== want.nut_vent || got.water_vent !== want.water_vent ||
              got.mode !== want.mode || got.keep !== want.keep ||
              got.status !== want.status) begin
            if (failures < 10) begin
              $display("[%0t] report mismatch", $time);
              $display("  expected %s", show_report(want));
              $display("  actual   %s", show_report(got));
            end
            failures++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        n = pick_gap(out_stall_pct);
        out_ready  <= (n == 0);
        stall_left <= (n == 0) ? 0 : n - 1;
      end
    end
  end

  // Count cycles with no traffic on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[%0t] no traffic for %0d cycles", $time, QUIET_LIMIT);
    $display("compressor_valve_mode_controller regression: fail");
    $finish;
  end

  // Write one inversion register and mirror it in the prediction
  task automatic write_reg(input logic [cvmc_pkg::CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cvmc_pkg::CFG_NUT_INV:   inv.nut   = val;
      cvmc_pkg::CFG_TANK_INV:  inv.tank  = val;
      cvmc_pkg::CFG_WATER_INV: inv.water = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued request is taken and every report is back
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    cvmc_pkg::inv_t settings[NUM_PHASES];
    int unsigned    in_pcts[NUM_PHASES];
    int unsigned    out_pcts[NUM_PHASES];
    int unsigned    legal;
    cmd_req_t       r;

    plant = '0;
    inv   = '0;
    foreach (status_hits[i]) status_hits[i] = 0;
    settings = '{3'b000, 3'b111, 3'b010, 3'b101, 3'b000, 3'b000};
    settings[4] = cvmc_pkg::inv_t'(3'($urandom_range(7)));
    settings[5] = cvmc_pkg::inv_t'(3'($urandom_range(7)));
    in_pcts  = '{0, 30, 10, 50, 20, 0};
    out_pcts = '{0, 30, 50, 10, 20, 40};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Change inversion only while the controller is idle
      write_reg(cvmc_pkg::CFG_NUT_INV, settings[p].nut);
      write_reg(cvmc_pkg::CFG_TANK_INV, settings[p].tank);
      write_reg(cvmc_pkg::CFG_WATER_INV, settings[p].water);
      in_gap_pct    = in_pcts[p];
      out_stall_pct = out_pcts[p];

      if (p == 0) begin
        // Vents, interlocks, mode merging and keep-connected corners
        queue_request(cvmc_pkg::CMD_KEEP_LINK, 8'hFF, 1'b0);
        queue_request(cvmc_pkg::CMD_NUT_CLOSE, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_WATER_CLOSE, 8'h00, 1'b1);
        queue_request(cvmc_pkg::CMD_NUT_OPEN, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_NUT_OPEN, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_COMP_NUT, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_NUT_CLOSE, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_WATER_OPEN, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_COMP_WATER, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_WATER_CLOSE, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_COMP_TANK, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_COMP_TANK, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_COMP_WATER, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_COMP_NUT, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_WATER_OPEN, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_KEEP_LINK, 8'h00, 1'b1);
        queue_request(cvmc_pkg::CMD_KEEP_LINK, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_SET_MODE, cvmc_pkg::MODE_OFF, 1'b0);
        queue_request(cvmc_pkg::CMD_KEEP_LINK, 8'h00, 1'b1);
        queue_request(cvmc_pkg::CMD_COMP_TANK, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_NUT_OPEN, 8'h00, 1'b0);
        queue_request(cvmc_pkg::CMD_SET_MODE, 8'd7, 1'b1);
        queue_request(cvmc_pkg::CMD_SET_MODE, 8'hFF, 1'b0);
        queue_request(4'hF, 8'hAA, 1'b1);
        queue_request(cvmc_pkg::CMD_OFF, 8'h55, 1'b1);
        queue_request(cvmc_pkg::CMD_SET_MODE, cvmc_pkg::MODE_IDLE, 1'b0);
      end

      // Random commands; unused codes ride along but do not count
      legal = 0;
      while (legal < ((p == 0) ? 70 : 75)) begin
        r = random_request();
        cmd_backlog.push_back(r);
        if (r.cmd <= cvmc_pkg::CMD_KEEP_LINK) legal++;
      end
      wait_quiet();
    end

    repeat (4) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0d reports never arrived", expected_reports.size());
      failures += expected_reports.size();
    end

    $display("Ran %0d commands (%0d unused codes) over %0d inversion settings, %0d reports",
             cmds_taken, unused_taken, NUM_PHASES, reports_seen);
    $display("Status mix: done %0d, no change %0d, refused %0d, unknown mode %0d; failures %0d",
             status_hits[cvmc_pkg::ST_DONE], status_hits[cvmc_pkg::ST_SAME],
             status_hits[cvmc_pkg::ST_REFUSED], status_hits[cvmc_pkg::ST_UNKNOWN], failures);
    if (failures == 0) begin
      $display("compressor_valve_mode_controller regression: pass");
    end else begin
      $display("compressor_valve_mode_controller regression: fail");
    end
    $finish;
  end

endmodule
